// ----- design/bmss_pkg.sv -----
// ----------------------------------------------------------------------------
// bmss_pkg: shared constants for the bounded multiset subset sum block
// Sizes of the coin store, the half-sum store and the derived widths.
// ----------------------------------------------------------------------------
package bmss_pkg;

   localparam int MAX_COINS   = 16;
   localparam int COIN_IDX_W  = $clog2(MAX_COINS);
   localparam int COUNT_W     = $clog2(MAX_COINS + 1);
   localparam int DIGITS      = (MAX_COINS + 1) / 2;
   localparam int DIG_IDX_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int KCNT_W      = $clog2(DIGITS + 1);
   localparam int SUM_DEPTH   = 8192;
   localparam int SUM_ADDR_W  = $clog2(SUM_DEPTH);
   localparam int SUM_COUNT_W = $clog2(SUM_DEPTH + 1);
   localparam int VALUE_W     = 32;
   localparam int ACC_W       = VALUE_W + 2;

   localparam logic [1:0] DIGIT_MAX = 2'd2;

endpackage

// ----- design/bounded_multiset_subset_sum.sv -----
// ----------------------------------------------------------------------------
// bounded_multiset_subset_sum: exact-sum search over coins used 0, 1 or 2 times
// Loads coins, then decides by meet in the middle with a sorted half-sum store.
// ----------------------------------------------------------------------------
// Coins arrive on the req_ channel, one transfer per cycle while the block is
// idle; req_tlast marks the final coin of a set. The csr_ port writes the
// target sum; the user must write it only while the block is idle (not enforced).
// On the final coin the block runs its search: it walks every base-3 choice of
// the left half through one shared adder/compare (one coin per cycle), stores
// the sums that fit under the target, heap-sorts that store with its single
// port, then walks the right half and binary searches the store for each
// candidate. The left half holds nl = floor(n/2) coins and the right half
// nr = n - nl; at most 3^nl sums are stored. Partial sums over the target are
// pruned, and a match ends the search. req_tready is low for the whole search.
// One transfer on rsp_ follows each final coin, holding found and the
// too-many-coins flag. If the receiver stalls, the result is held and the next
// set can still be loaded; its search runs, but its result waits for the held
// one to go, and the input stays stalled meanwhile.
// A synchronous reset clears the coin count, the flags and the target.
// ----------------------------------------------------------------------------
module bounded_multiset_subset_sum
   import bmss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [VALUE_W-1:0]  req_tdata,    // [31:0] coin_value
   input  logic                req_tlast,    // last_coin
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,    // [0] found, [1] too_many_coins, [7:2] zero
   input  logic                csr_we,
   input  logic [VALUE_W-1:0]  csr_wdata
);

   localparam logic [4:0] ST_IDLE       = 5'd0;
   localparam logic [4:0] ST_PREP       = 5'd1;
   localparam logic [4:0] ST_EN_ACC     = 5'd2;
   localparam logic [4:0] ST_EN_NEXT    = 5'd3;
   localparam logic [4:0] ST_BS_LOOP    = 5'd4;
   localparam logic [4:0] ST_BS_CMP     = 5'd5;
   localparam logic [4:0] ST_BS_EQ      = 5'd6;
   localparam logic [4:0] ST_SORT_INIT  = 5'd7;
   localparam logic [4:0] ST_SIFT_START = 5'd8;
   localparam logic [4:0] ST_SIFT_GETV  = 5'd9;
   localparam logic [4:0] ST_CHILD      = 5'd10;
   localparam logic [4:0] ST_CHILD_L    = 5'd11;
   localparam logic [4:0] ST_CHILD_R    = 5'd12;
   localparam logic [4:0] ST_SIFT_DONE  = 5'd13;
   localparam logic [4:0] ST_EXT_A      = 5'd14;
   localparam logic [4:0] ST_EXT_B      = 5'd15;
   localparam logic [4:0] ST_EXT_C      = 5'd16;
   localparam logic [4:0] ST_RIGHT_INIT = 5'd17;
   localparam logic [4:0] ST_OUT        = 5'd18;

   logic [4:0]              state_ff, state_in;
   logic [VALUE_W-1:0]      coin_mem_ff [MAX_COINS];
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic                    ovf_ff, ovf_in;
   logic [VALUE_W-1:0]      target_ff;
   logic [SUM_COUNT_W-1:0]  lsc_ff, lsc_in;
   logic [COIN_IDX_W-1:0]   first_ff, first_in;
   logic [KCNT_W-1:0]       cnt_ff, cnt_in;
   logic [KCNT_W-1:0]       k_ff, k_in;
   logic [1:0]              dig_ff [DIGITS];
   logic [1:0]              dig_in [DIGITS];
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic                    right_ff, right_in;
   logic [VALUE_W-1:0]      key_ff, key_in;
   logic [SUM_COUNT_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [SUM_ADDR_W-1:0]   mid_ff, mid_in;
   logic [VALUE_W-1:0]      val_ff, val_in, lv_ff, lv_in, top_ff, top_in;
   logic [SUM_COUNT_W-1:0]  pos_ff, pos_in, len_ff, len_in;
   logic [SUM_ADDR_W-1:0]   i_ff, i_in, end_ff, end_in;
   logic                    build_ff, build_in;
   logic                    res_found_ff, res_found_in, res_over_ff, res_over_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in, rsp_over_ff, rsp_over_in;

   logic [VALUE_W-1:0]      sum_mem [SUM_DEPTH];
   logic [VALUE_W-1:0]      rd_data_ff;
   logic                    mem_re, mem_we;
   logic [SUM_ADDR_W-1:0]   mem_addr;
   logic [VALUE_W-1:0]      mem_wdata;

   logic                    req_xfer;
   logic [COIN_IDX_W-1:0]   coin_idx;
   logic [VALUE_W-1:0]      coin_sel;
   logic [1:0]              dig_sel;
   logic [ACC_W-1:0]        addend, acc_sum;
   logic [SUM_COUNT_W:0]    l_idx, r_idx, mid_sum;
   logic                    carry;
   logic                    l_big;
   logic [VALUE_W-1:0]      big_v;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_over_ff, rsp_found_ff};

   // Shared adder: adds 0, 1 or 2 times the selected coin to the running sum.
   assign coin_idx = first_ff + COIN_IDX_W'(k_ff);
   assign coin_sel = coin_mem_ff[coin_idx];
   assign dig_sel  = dig_ff[k_ff[DIG_IDX_W-1:0]];
   always_comb begin
      case (dig_sel)
         2'd1:    addend = {2'b00, coin_sel};
         2'd2:    addend = {1'b0, coin_sel, 1'b0};
         default: addend = '0;
      endcase
   end
   assign acc_sum = acc_ff + addend;

   assign l_idx   = {pos_ff, 1'b1};
   assign r_idx   = l_idx + 1'b1;
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign l_big   = lv_ff > val_ff;
   assign big_v   = l_big ? lv_ff : val_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      lsc_in       = lsc_ff;
      first_in     = first_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      dig_in       = dig_ff;
      acc_in       = acc_ff;
      right_in     = right_ff;
      key_in       = key_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      val_in       = val_ff;
      lv_in        = lv_ff;
      top_in       = top_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      i_in         = i_ff;
      end_in       = end_ff;
      build_in     = build_ff;
      res_found_in = res_found_ff;
      res_over_in  = res_over_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_over_in  = rsp_over_ff;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = '0;
      mem_wdata    = val_ff;
      carry        = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (count_ff < COUNT_W'(MAX_COINS)) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            if (ovf_ff) begin
               res_found_in = 1'b0;
               res_over_in  = 1'b1;
               state_in     = ST_OUT;
            end else begin
               res_over_in = 1'b0;
               first_in    = '0;
               cnt_in      = KCNT_W'(count_ff >> 1);
               lsc_in      = '0;
               for (int j = 0; j < DIGITS; j++) dig_in[j] = '0;
               acc_in      = '0;
               k_in        = '0;
               right_in    = 1'b0;
               state_in    = ST_EN_ACC;
            end
         end
         ST_EN_ACC: begin
            if (k_ff == cnt_ff) begin
               if (!right_ff) begin
                  if (lsc_ff < SUM_COUNT_W'(SUM_DEPTH)) begin
                     mem_we    = 1'b1;
                     mem_addr  = lsc_ff[SUM_ADDR_W-1:0];
                     mem_wdata = acc_ff[VALUE_W-1:0];
                     lsc_in    = lsc_ff + 1'b1;
                  end
                  state_in = ST_EN_NEXT;
               end else begin
                  key_in   = target_ff - acc_ff[VALUE_W-1:0];
                  lo_in    = '0;
                  hi_in    = lsc_ff;
                  state_in = ST_BS_LOOP;
               end
            end else if (acc_sum > {2'b00, target_ff}) begin
               state_in = ST_EN_NEXT;
            end else begin
               acc_in = acc_sum;
               k_in   = k_ff + 1'b1;
            end
         end
         ST_EN_NEXT: begin
            // Base-3 odometer over the digits of the current half.
            for (int j = 0; j < DIGITS; j++) begin
               if (carry && (KCNT_W'(j) < cnt_ff)) begin
                  if (dig_ff[j] == DIGIT_MAX) begin
                     dig_in[j] = '0;
                  end else begin
                     dig_in[j] = dig_ff[j] + 1'b1;
                     carry     = 1'b0;
                  end
               end
            end
            acc_in = '0;
            k_in   = '0;
            if (carry) begin
               if (right_ff) begin
                  res_found_in = 1'b0;
                  state_in     = ST_OUT;
               end else begin
                  state_in = ST_SORT_INIT;
               end
            end else begin
               state_in = ST_EN_ACC;
            end
         end
         ST_BS_LOOP: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_sum[SUM_ADDR_W:1];
               mem_re   = 1'b1;
               mem_addr = mid_sum[SUM_ADDR_W:1];
               state_in = ST_BS_CMP;
            end else if (lo_ff < lsc_ff) begin
               mem_re   = 1'b1;
               mem_addr = lo_ff[SUM_ADDR_W-1:0];
               state_in = ST_BS_EQ;
            end else begin
               state_in = ST_EN_NEXT;
            end
         end
         ST_BS_CMP: begin
            if (rd_data_ff < key_ff) begin
               lo_in = SUM_COUNT_W'(mid_ff) + 1'b1;
            end else begin
               hi_in = SUM_COUNT_W'(mid_ff);
            end
            state_in = ST_BS_LOOP;
         end
         ST_BS_EQ: begin
            if (rd_data_ff == key_ff) begin
               res_found_in = 1'b1;
               state_in     = ST_OUT;
            end else begin
               state_in = ST_EN_NEXT;
            end
         end
         ST_SORT_INIT: begin
            if (lsc_ff < SUM_COUNT_W'(2)) begin
               state_in = ST_RIGHT_INIT;
            end else begin
               build_in = 1'b1;
               i_in     = SUM_ADDR_W'((lsc_ff >> 1) - 1'b1);
               len_in   = lsc_ff;
               state_in = ST_SIFT_START;
            end
         end
         ST_SIFT_START: begin
            mem_re   = 1'b1;
            mem_addr = i_ff;
            pos_in   = SUM_COUNT_W'(i_ff);
            state_in = ST_SIFT_GETV;
         end
         ST_SIFT_GETV: begin
            val_in   = rd_data_ff;
            state_in = ST_CHILD;
         end
         ST_CHILD: begin
            if (l_idx < {1'b0, len_ff}) begin
               mem_re   = 1'b1;
               mem_addr = l_idx[SUM_ADDR_W-1:0];
               state_in = ST_CHILD_L;
            end else begin
               mem_we   = 1'b1;
               mem_addr = pos_ff[SUM_ADDR_W-1:0];
               state_in = ST_SIFT_DONE;
            end
         end
         ST_CHILD_L: begin
            lv_in = rd_data_ff;
            if (r_idx < {1'b0, len_ff}) begin
               mem_re   = 1'b1;
               mem_addr = r_idx[SUM_ADDR_W-1:0];
               state_in = ST_CHILD_R;
            end else if (rd_data_ff > val_ff) begin
               mem_we    = 1'b1;
               mem_addr  = pos_ff[SUM_ADDR_W-1:0];
               mem_wdata = rd_data_ff;
               pos_in    = l_idx[SUM_COUNT_W-1:0];
               state_in  = ST_CHILD;
            end else begin
               mem_we   = 1'b1;
               mem_addr = pos_ff[SUM_ADDR_W-1:0];
               state_in = ST_SIFT_DONE;
            end
         end
         ST_CHILD_R: begin
            mem_we   = 1'b1;
            mem_addr = pos_ff[SUM_ADDR_W-1:0];
            if (rd_data_ff > big_v) begin
               mem_wdata = rd_data_ff;
               pos_in    = r_idx[SUM_COUNT_W-1:0];
               state_in  = ST_CHILD;
            end else if (l_big) begin
               mem_wdata = lv_ff;
               pos_in    = l_idx[SUM_COUNT_W-1:0];
               state_in  = ST_CHILD;
            end else begin
               state_in = ST_SIFT_DONE;
            end
         end
         ST_SIFT_DONE: begin
            if (build_ff) begin
               if (i_ff == '0) begin
                  build_in = 1'b0;
                  end_in   = SUM_ADDR_W'(lsc_ff - 1'b1);
                  state_in = ST_EXT_A;
               end else begin
                  i_in     = i_ff - 1'b1;
                  state_in = ST_SIFT_START;
               end
            end else if (end_ff == SUM_ADDR_W'(1)) begin
               state_in = ST_RIGHT_INIT;
            end else begin
               end_in   = end_ff - 1'b1;
               state_in = ST_EXT_A;
            end
         end
         ST_EXT_A: begin
            mem_re   = 1'b1;
            mem_addr = '0;
            state_in = ST_EXT_B;
         end
         ST_EXT_B: begin
            top_in   = rd_data_ff;
            mem_re   = 1'b1;
            mem_addr = end_ff;
            state_in = ST_EXT_C;
         end
         ST_EXT_C: begin
            // The largest sum moves to the end; the old last entry sifts from the root.
            val_in    = rd_data_ff;
            mem_we    = 1'b1;
            mem_addr  = end_ff;
            mem_wdata = top_ff;
            pos_in    = '0;
            len_in    = SUM_COUNT_W'(end_ff);
            state_in  = ST_CHILD;
         end
         ST_RIGHT_INIT: begin
            first_in = COIN_IDX_W'(count_ff >> 1);
            cnt_in   = KCNT_W'(count_ff - (count_ff >> 1));
            for (int j = 0; j < DIGITS; j++) dig_in[j] = '0;
            acc_in   = '0;
            k_in     = '0;
            right_in = 1'b1;
            state_in = ST_EN_ACC;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_over_in  = res_over_ff;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         target_ff    <= '0;
         lsc_ff       <= '0;
         build_ff     <= 1'b0;
         right_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         lsc_ff       <= lsc_in;
         build_ff     <= build_in;
         right_ff     <= right_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            target_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      first_ff     <= first_in;
      cnt_ff       <= cnt_in;
      k_ff         <= k_in;
      dig_ff       <= dig_in;
      acc_ff       <= acc_in;
      key_ff       <= key_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      val_ff       <= val_in;
      lv_ff        <= lv_in;
      top_ff       <= top_in;
      pos_ff       <= pos_in;
      len_ff       <= len_in;
      i_ff         <= i_in;
      end_ff       <= end_in;
      res_found_ff <= res_found_in;
      res_over_ff  <= res_over_in;
      rsp_found_ff <= rsp_found_in;
      rsp_over_ff  <= rsp_over_in;
   end

   always_ff @(posedge clock) begin
      if (req_xfer && (count_ff < COUNT_W'(MAX_COINS))) begin
         coin_mem_ff[count_ff[COIN_IDX_W-1:0]] <= req_tdata;
      end
   end

   // Single-port half-sum store with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= sum_mem[mem_addr];
      end
   end

endmodule
